// ===== rtl/paging_responder_macros.svh =====
// ----------------------------------------------------------------------------
// paging_responder_macros - assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef PAGING_RESPONDER_MACROS_SVH
`define PAGING_RESPONDER_MACROS_SVH

// Plain implication check.
`define PR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition must never be true.
`define PR_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/pr_pkg.sv =====
// ----------------------------------------------------------------------------
// pr_pkg - paging responder package
// Constants, burst descriptor type and slot window check.
// ----------------------------------------------------------------------------
package pr_pkg;

    // input item modes
    localparam logic [1:0] MODE_BYTE = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_PAGE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_ID  = 2'd0;
    localparam logic [1:0] CFG_QUALITY = 2'd1;
    localparam logic [1:0] CFG_CAPAB   = 2'd2;

    // reset values
    localparam logic [31:0] OWN_ID_RST  = 32'd0;
    localparam logic [7:0]  QUALITY_RST = 8'd100;
    localparam logic [7:0]  CAPAB_RST   = 8'h10;

    localparam logic [7:0] PKT_TYPE  = 8'd11;
    localparam logic [7:0] RESP_TYPE = 8'd21;

    // burst kinds
    localparam logic OP_NOTICE = 1'b0;
    localparam logic OP_RESP   = 1'b1;

    // result kinds
    localparam logic KIND_NOTICE = 1'b0;
    localparam logic KIND_BYTE   = 1'b1;

    // access windows
    localparam logic [11:0] WIN0_LO = 12'd630;
    localparam logic [11:0] WIN0_HI = 12'd808;
    localparam logic [11:0] WIN1_LO = 12'd1350;
    localparam logic [11:0] WIN1_HI = 12'd1528;
    localparam logic [11:0] WIN2_LO = 12'd2070;
    localparam logic [11:0] WIN2_HI = 12'd2248;

    // response burst: 7 bytes then idle notice
    localparam logic [2:0] RESP_LAST = 3'd7;

    typedef struct packed {
        logic        op;    // OP_NOTICE or OP_RESP
        logic        st;    // notice state
        logic [11:0] slot;  // response slot
    } t_desc;

    function automatic logic in_window(input logic [11:0] s);
        in_window = (s >= WIN0_LO && s <= WIN0_HI) ||
                    (s >= WIN1_LO && s <= WIN1_HI) ||
                    (s >= WIN2_LO && s <= WIN2_HI);
    endfunction

endpackage

// ===== rtl/pr_parser.sv =====
// ----------------------------------------------------------------------------
// pr_parser - packet parser and responder state
// Tracks packet position and the responding flag; issues one burst
// descriptor per accepted item that yields results.
// ----------------------------------------------------------------------------
module pr_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [1:0]    i_mode,
    input  logic [7:0]    i_packet_byte,
    input  logic          i_end_of_packet,
    input  logic [11:0]   i_slot_number,
    input  logic [31:0]   i_paged_id,
    input  logic [31:0]   i_own_id,
    output logic          o_desc_vld,
    output pr_pkg::t_desc o_desc
);

    logic        r_resp, n_resp;
    logic [2:0]  r_pos, n_pos;
    logic        r_type_ok, n_type_ok;
    logic [23:0] r_col, n_col;
    logic        r_match, n_match;

    always_comb begin
        n_resp     = r_resp;
        n_pos      = r_pos;
        n_type_ok  = r_type_ok;
        n_col      = r_col;
        n_match    = r_match;
        o_desc_vld = 1'b0;
        o_desc     = '0;
        if (i_accept) begin
            unique case (i_mode)
                pr_pkg::MODE_BYTE: begin
                    priority if (r_pos == 3'd0) begin
                        n_type_ok = (i_packet_byte == pr_pkg::PKT_TYPE);
                        n_pos     = 3'd1;
                    end else if (r_pos < 3'd3) begin
                        n_pos = r_pos + 3'd1;
                    end else if (r_pos < 3'd6) begin
                        n_col = {r_col[15:0], i_packet_byte};
                        n_pos = r_pos + 3'd1;
                    end else begin
                        if (r_type_ok && !r_match &&
                            ({r_col, i_packet_byte} == i_own_id)) begin
                            n_match    = 1'b1;
                            n_resp     = 1'b1;
                            o_desc_vld = 1'b1;
                            o_desc.op  = pr_pkg::OP_NOTICE;
                            o_desc.st  = 1'b1;
                        end
                        n_col = '0;
                        n_pos = 3'd3;
                    end
                    if (i_end_of_packet) begin
                        n_pos     = 3'd0;
                        n_type_ok = 1'b0;
                        n_col     = '0;
                        n_match   = 1'b0;
                    end
                end
                pr_pkg::MODE_TICK: begin
                    if (r_resp && pr_pkg::in_window(i_slot_number)) begin
                        o_desc_vld  = 1'b1;
                        o_desc.op   = pr_pkg::OP_RESP;
                        o_desc.slot = i_slot_number;
                        n_resp      = 1'b0;
                    end
                end
                pr_pkg::MODE_PAGE: begin
                    if (i_paged_id == i_own_id) begin
                        n_resp     = 1'b1;
                        o_desc_vld = 1'b1;
                        o_desc.op  = pr_pkg::OP_NOTICE;
                        o_desc.st  = 1'b1;
                    end
                end
                default: ;  // unused mode
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp    <= 1'b0;
            r_pos     <= 3'd0;
            r_type_ok <= 1'b0;
            r_col     <= '0;
            r_match   <= 1'b0;
        end else begin
            r_resp    <= n_resp;
            r_pos     <= n_pos;
            r_type_ok <= n_type_ok;
            r_col     <= n_col;
            r_match   <= n_match;
        end
    end

endmodule

// ===== rtl/pr_emitter.sv =====
// ----------------------------------------------------------------------------
// pr_emitter - result burst sequencer
// One pending and one active descriptor; steps through the result items
// of the active burst, one transfer per cycle while i_ready is high.
// ----------------------------------------------------------------------------
`include "paging_responder_macros.svh"

module pr_emitter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_desc_vld,
    input  pr_pkg::t_desc i_desc,
    output logic          o_in_ready,
    input  logic [31:0]   i_own_id,
    input  logic [7:0]    i_link_quality,
    input  logic [7:0]    i_capability_byte,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_kind,
    output logic [7:0]    o_frame_byte,
    output logic [11:0]   o_send_slot,
    output logic          o_new_state,
    output logic          o_last_of_run
);

    logic          r_pend_vld;
    pr_pkg::t_desc r_pend;
    logic          r_act_vld;
    pr_pkg::t_desc r_act;
    logic [2:0]    r_cnt;

    logic out_fire, act_done, act_free;

    assign out_fire   = r_act_vld && i_ready;
    assign act_done   = out_fire && o_last_of_run;
    assign act_free   = !r_act_vld || act_done;
    assign o_in_ready = !r_pend_vld;
    assign o_valid    = r_act_vld;

    // result fields from active descriptor and step
    always_comb begin
        o_kind        = pr_pkg::KIND_NOTICE;
        o_frame_byte  = '0;
        o_send_slot   = '0;
        o_new_state   = 1'b0;
        o_last_of_run = 1'b1;
        if (r_act.op == pr_pkg::OP_RESP) begin
            o_last_of_run = (r_cnt == pr_pkg::RESP_LAST);
            if (r_cnt != pr_pkg::RESP_LAST) begin
                o_kind      = pr_pkg::KIND_BYTE;
                o_send_slot = r_act.slot;
            end
            unique case (r_cnt)
                3'd0:    o_frame_byte = pr_pkg::RESP_TYPE;
                3'd1:    o_frame_byte = i_own_id[31:24];
                3'd2:    o_frame_byte = i_own_id[23:16];
                3'd3:    o_frame_byte = i_own_id[15:8];
                3'd4:    o_frame_byte = i_own_id[7:0];
                3'd5:    o_frame_byte = i_capability_byte;
                3'd6:    o_frame_byte = i_link_quality;
                default: o_frame_byte = '0;  // closing idle notice
            endcase
        end else begin
            o_new_state = r_act.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_act_vld  <= 1'b0;
            r_cnt      <= 3'd0;
        end else begin
            if (act_free) begin
                r_cnt <= 3'd0;
                if (r_pend_vld) begin
                    r_act_vld  <= 1'b1;
                    r_pend_vld <= i_desc_vld;
                end else begin
                    r_act_vld  <= i_desc_vld;
                end
            end else begin
                if (out_fire) r_cnt <= r_cnt + 3'd1;
                if (i_desc_vld) r_pend_vld <= 1'b1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (act_free) begin
            if (r_pend_vld) begin
                r_act  <= r_pend;
                r_pend <= i_desc;
            end else begin
                r_act  <= i_desc;
            end
        end else if (i_desc_vld) begin
            r_pend <= i_desc;
        end
    end

    `PR_ASSERT(a_pend_behind_act, r_pend_vld |-> r_act_vld, "pending burst without active one")
    `PR_ASSERT(a_cnt_resp_only, (r_cnt != 3'd0) |-> (r_act_vld && r_act.op == pr_pkg::OP_RESP), "step count outside response burst")
    `PR_ASSERT(a_stall_holds, (r_act_vld && !i_ready) |=> (r_act_vld && $stable(r_cnt)), "stalled result moved")
    `PR_NEVER(a_no_overrun, i_desc_vld && r_pend_vld && !act_free, "descriptor overruns pending slot")

endmodule

// ===== rtl/paging_responder.sv =====
// ----------------------------------------------------------------------------
// paging_responder - paging receiver and responder
// Parses paging packets byte by byte, tracks the responding state and
// sends the seven-byte response burst on a slot tick inside an access window.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  input    | i_valid / o_ready       | i_mode, i_packet_byte, i_end_of_packet,
//           |                         | i_slot_number, i_paged_id
//  result   | o_valid / i_ready       | o_kind, o_frame_byte, o_send_slot,
//           |                         | o_new_state, o_last_of_run
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  An input item is parsed in the cycle of its transfer; its results are
//  registered and leave one result transfer per cycle while i_ready is
//  high. A notice item gives one result transfer, a response burst eight.
//  Items flow at one per cycle; the sequencer holds one burst in work and
//  one pending, so o_ready drops only while a burst waits behind another.
//  Synchronous active-low reset clears parser state and the burst queue and
//  restores register defaults. The config port is always ready.
//
module paging_responder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_packet_byte,
    input  logic        i_end_of_packet,
    input  logic [11:0] i_slot_number,
    input  logic [31:0] i_paged_id,
    // results
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_frame_byte,
    output logic [11:0] o_send_slot,
    output logic        o_new_state,
    output logic        o_last_of_run,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // configuration registers
    logic [31:0] r_own_id;
    logic [7:0]  r_link_quality;
    logic [7:0]  r_capability_byte;

    logic          accept;
    logic          desc_vld;
    pr_pkg::t_desc desc;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    // register writes; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id          <= pr_pkg::OWN_ID_RST;
            r_link_quality    <= pr_pkg::QUALITY_RST;
            r_capability_byte <= pr_pkg::CAPAB_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pr_pkg::CFG_OWN_ID:  r_own_id          <= i_cfg_data;
                pr_pkg::CFG_QUALITY: r_link_quality    <= i_cfg_data[7:0];
                pr_pkg::CFG_CAPAB:   r_capability_byte <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // parser: packet position, id collection, responding flag
    pr_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_mode          (i_mode),
        .i_packet_byte   (i_packet_byte),
        .i_end_of_packet (i_end_of_packet),
        .i_slot_number   (i_slot_number),
        .i_paged_id      (i_paged_id),
        .i_own_id        (r_own_id),
        .o_desc_vld      (desc_vld),
        .o_desc          (desc)
    );

    // burst sequencer: turns descriptors into result transfers
    pr_emitter u_emitter (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_desc_vld        (desc_vld),
        .i_desc            (desc),
        .o_in_ready        (o_ready),
        .i_own_id          (r_own_id),
        .i_link_quality    (r_link_quality),
        .i_capability_byte (r_capability_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_frame_byte      (o_frame_byte),
        .o_send_slot       (o_send_slot),
        .o_new_state       (o_new_state),
        .o_last_of_run     (o_last_of_run)
    );

endmodule

// ===== tb/paging_responder_tb.sv =====
// ----------------------------------------------------------------------------
// paging_responder_tb - self-checking testbench for the paging responder
// Drives packet bytes, slot ticks and direct pages through the input channel,
// predicts every notice and response byte with an independent model of the
// parser and responder, and checks each result transfer in order. Directed
// tests cover register defaults, packet parsing rules, access window edges
// and output backpressure; random phases cover the rest under several
// register settings.
// ----------------------------------------------------------------------------
module paging_responder_tb;

    // ------------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------------
    localparam int RESET_CYCLES  = 6;
    localparam int ITEM_TARGET   = 380;     // total input items, all tests
    localparam int PHASE_ITEMS   = 60;      // random items per register setting
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 12;      // one burst in work plus one pending
    localparam int DRAIN_LIMIT   = 20000;   // cycles allowed to empty the queue
    localparam int RUN_LIMIT     = 400000;  // absolute time limit
    localparam int REPORT_LIMIT  = 10;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // parser byte positions
    localparam logic [2:0] POS_TYPE     = 3'd0;
    localparam logic [2:0] POS_FIRST_ID = 3'd3;
    localparam logic [2:0] POS_LAST_ID  = 3'd6;

    localparam int SLOT_MAX = 2249;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_mode;
    logic [7:0]  i_packet_byte;
    logic        i_end_of_packet;
    logic [11:0] i_slot_number;
    logic [31:0] i_paged_id;
    logic        o_valid;
    logic        i_ready;
    logic        o_kind;
    logic [7:0]  o_frame_byte;
    logic [11:0] o_send_slot;
    logic        o_new_state;
    logic        o_last_of_run;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    paging_responder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_packet_byte   (i_packet_byte),
        .i_end_of_packet (i_end_of_packet),
        .i_slot_number   (i_slot_number),
        .i_paged_id      (i_paged_id),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_frame_byte    (o_frame_byte),
        .o_send_slot     (o_send_slot),
        .o_new_state     (o_new_state),
        .o_last_of_run   (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // One result transfer, in port order.
    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_byte;
        logic [11:0] send_slot;
        logic        new_state;
        logic        last_of_run;
    } t_result;

    // Expected result transfers, oldest first.
    t_result pending_results[$];

    // Predictor copy of the registers and the responder state.
    logic [31:0] model_own_id;
    logic [7:0]  model_quality;
    logic [7:0]  model_capab;
    logic        model_responding;
    logic [2:0]  model_byte_pos;
    logic        model_type_ok;
    logic [23:0] model_id_acc;
    logic        model_matched;

    // Stimulus side: the identifier currently programmed.
    logic [31:0] stim_own_id;

    int  error_count;
    int  items_sent;
    bit  gaps_on;          // sender idles between bursts when set
    int  burst_left;
    bit  hold_request;     // asks the receiver for a long hold-off

    // ------------------------------------------------------------------------
    // Clock and time limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Error reporting: first few in full, the rest only counted
    // ------------------------------------------------------------------------
    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] ERROR: %s", $time, msg);
    endtask

    function automatic logic is_access_slot(input logic [11:0] s);
        return (s >= pr_pkg::WIN0_LO && s <= pr_pkg::WIN0_HI) ||
               (s >= pr_pkg::WIN1_LO && s <= pr_pkg::WIN1_HI) ||
               (s >= pr_pkg::WIN2_LO && s <= pr_pkg::WIN2_HI);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: works out the results one accepted input item causes and
    // appends them to pending_results. The last one of the run carries the
    // last_of_run flag.
    // ------------------------------------------------------------------------
    task automatic predict_paging_results(input logic [1:0]  mode,
                                          input logic [7:0]  pb,
                                          input logic        eop,
                                          input logic [11:0] slot,
                                          input logic [31:0] pid);
        t_result run_buf [8];
        int      n;
        n = 0;
        case (mode)
            pr_pkg::MODE_BYTE: begin
                if (model_byte_pos == POS_TYPE) begin
                    model_type_ok  = (pb == pr_pkg::PKT_TYPE);
                    model_byte_pos = model_byte_pos + 3'd1;
                end else if (model_byte_pos < POS_FIRST_ID) begin
                    // two header bytes skipped
                    model_byte_pos = model_byte_pos + 3'd1;
                end else if (model_byte_pos < POS_LAST_ID) begin
                    model_id_acc   = {model_id_acc[15:0], pb};
                    model_byte_pos = model_byte_pos + 3'd1;
                end else begin
                    // fourth byte of a group completes the identifier
                    if (model_type_ok && !model_matched &&
                        {model_id_acc, pb} == model_own_id) begin
                        model_matched    = 1'b1;
                        model_responding = 1'b1;
                        run_buf[n] = {pr_pkg::KIND_NOTICE, 8'd0, 12'd0, 1'b1, 1'b0};
                        n++;
                    end
                    model_id_acc   = '0;
                    model_byte_pos = POS_FIRST_ID;
                end
                if (eop) begin
                    // partial group dropped, parse restarts at next byte
                    model_byte_pos = POS_TYPE;
                    model_type_ok  = 1'b0;
                    model_id_acc   = '0;
                    model_matched  = 1'b0;
                end
            end
            pr_pkg::MODE_TICK: begin
                if (model_responding && is_access_slot(slot)) begin
                    run_buf[0] = {pr_pkg::KIND_BYTE, pr_pkg::RESP_TYPE, slot, 1'b0, 1'b0};
                    run_buf[1] = {pr_pkg::KIND_BYTE, model_own_id[31:24], slot, 1'b0, 1'b0};
                    run_buf[2] = {pr_pkg::KIND_BYTE, model_own_id[23:16], slot, 1'b0, 1'b0};
                    run_buf[3] = {pr_pkg::KIND_BYTE, model_own_id[15:8],  slot, 1'b0, 1'b0};
                    run_buf[4] = {pr_pkg::KIND_BYTE, model_own_id[7:0],   slot, 1'b0, 1'b0};
                    run_buf[5] = {pr_pkg::KIND_BYTE, model_capab,         slot, 1'b0, 1'b0};
                    run_buf[6] = {pr_pkg::KIND_BYTE, model_quality,       slot, 1'b0, 1'b0};
                    run_buf[7] = {pr_pkg::KIND_NOTICE, 8'd0, 12'd0, 1'b0, 1'b0};
                    n = 8;
                    model_responding = 1'b0;
                end
            end
            pr_pkg::MODE_PAGE: begin
                if (pid == model_own_id) begin
                    model_responding = 1'b1;
                    run_buf[n] = {pr_pkg::KIND_NOTICE, 8'd0, 12'd0, 1'b1, 1'b0};
                    n++;
                end
            end
            default: ;  // unused mode, no effect
        endcase
        for (int k = 0; k < n; k++) begin
            if (k == n - 1)
                run_buf[k].last_of_run = 1'b1;
            pending_results.push_back(run_buf[k]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard: everything is sampled at the rising edge, before the
    // nonblocking updates of that edge land, so the values seen are the
    // ones the DUT acted on. Results are checked before the item of the
    // same edge is predicted; a result never leaves in the transfer cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            model_own_id     = pr_pkg::OWN_ID_RST;
            model_quality    = pr_pkg::QUALITY_RST;
            model_capab      = pr_pkg::CAPAB_RST;
            model_responding = 1'b0;
            model_byte_pos   = POS_TYPE;
            model_type_ok    = 1'b0;
            model_id_acc     = '0;
            model_matched    = 1'b0;
            pending_results.delete();
        end else begin
            if (o_valid === 1'b1 && i_ready === 1'b1) begin
                got = {o_kind, o_frame_byte, o_send_slot, o_new_state, o_last_of_run};
                if (pending_results.size() == 0) begin
                    note_error($sformatf(
                        "unexpected result kind=%0d byte=%02h slot=%0d state=%0d last=%0d",
                        got.kind, got.frame_byte, got.send_slot, got.new_state,
                        got.last_of_run));
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        note_error($sformatf({"result mismatch: expected kind=%0d ",
                            "byte=%02h slot=%0d state=%0d last=%0d, got kind=%0d ",
                            "byte=%02h slot=%0d state=%0d last=%0d"},
                            want.kind, want.frame_byte, want.send_slot,
                            want.new_state, want.last_of_run,
                            got.kind, got.frame_byte, got.send_slot,
                            got.new_state, got.last_of_run));
                end
            end
            // register write transfer
            if (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1) begin
                case (i_cfg_index)
                    pr_pkg::CFG_OWN_ID:  model_own_id  = i_cfg_data;
                    pr_pkg::CFG_QUALITY: model_quality = i_cfg_data[7:0];
                    pr_pkg::CFG_CAPAB:   model_capab   = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // input item transfer
            if (i_valid === 1'b1 && o_ready === 1'b1)
                predict_paging_results(i_mode, i_packet_byte, i_end_of_packet,
                                       i_slot_number, i_paged_id);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: i_ready follows a pattern that changes style now and then
    // (always ready, mostly ready, mostly stalled, periodic). A hold-off
    // request drops ready until its HOLD_CYCLES countdown, kept here, runs out.
    // ------------------------------------------------------------------------
    initial begin : ready_pattern
        int hold_left;
        int style;
        int style_left;
        int cyc;
        hold_left  = 0;
        style      = 0;
        style_left = 0;
        cyc        = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (style_left == 0) begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(40, 200);
            end
            style_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (style)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 3) != 0);
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= ((cyc % 7) < 5);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: one input item, held until its transfer. In gap mode the
    // sender works in bursts with idle stretches between them. Valid is
    // lowered here only before a gap, so back-to-back items keep it high.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0]  mode,
                             input logic [7:0]  pb,
                             input logic        eop,
                             input logic [11:0] slot,
                             input logic [31:0] pid);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0)
            burst_left--;
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_packet_byte   <= pb;
        i_end_of_packet <= eop;
        i_slot_number   <= slot;
        i_paged_id      <= pid;
        @(posedge i_clk);
        while (o_ready !== 1'b1)
            @(posedge i_clk);
        if (mode != MODE_UNUSED)
            items_sent++;
    endtask

    function automatic logic [11:0] rand_slot();
        return 12'($urandom_range(0, SLOT_MAX));
    endfunction

    // packet byte; the unused fields carry random content
    task automatic send_byte(input logic [7:0] pb, input logic eop);
        send_item(pr_pkg::MODE_BYTE, pb, eop, rand_slot(), $urandom());
    endtask

    task automatic send_tick(input logic [11:0] slot);
        send_item(pr_pkg::MODE_TICK, 8'($urandom()), 1'($urandom()), slot, $urandom());
    endtask

    task automatic send_page(input logic [31:0] pid);
        send_item(pr_pkg::MODE_PAGE, 8'($urandom()), 1'($urandom()), rand_slot(), pid);
    endtask

    // Idle the sender and wait until every expected result has arrived,
    // then a few more cycles in case the block is still busy. One edge is
    // let by first so the last transfer is already in the expected queue.
    task automatic wait_for_quiet();
        int cnt;
        cnt = 0;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 && cnt < DRAIN_LIMIT) begin
            @(posedge i_clk);
            cnt++;
        end
        if (pending_results.size() != 0) begin
            note_error($sformatf("timeout with %0d results outstanding",
                                 pending_results.size()));
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Register writes: only called while the block is quiet.
    // ------------------------------------------------------------------------
    task automatic write_register(input logic [1:0] index, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] id, input logic [7:0] quality,
                              input logic [7:0] capab);
        write_register(pr_pkg::CFG_OWN_ID, id);
        write_register(pr_pkg::CFG_QUALITY, {24'd0, quality});
        write_register(pr_pkg::CFG_CAPAB, {24'd0, capab});
        i_cfg_valid <= 1'b0;
        stim_own_id = id;
    endtask

    // ------------------------------------------------------------------------
    // Random item helpers
    // ------------------------------------------------------------------------
    // slot inside a window, edges favored
    function automatic logic [11:0] window_slot();
        logic [11:0] lo;
        logic [11:0] hi;
        int          w;
        w  = $urandom_range(0, 2);
        lo = (w == 0) ? pr_pkg::WIN0_LO : (w == 1) ? pr_pkg::WIN1_LO : pr_pkg::WIN2_LO;
        hi = (w == 0) ? pr_pkg::WIN0_HI : (w == 1) ? pr_pkg::WIN1_HI : pr_pkg::WIN2_HI;
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return 12'($urandom_range(lo, hi));
        endcase
    endfunction

    // slot outside every window, just-outside edges favored
    function automatic logic [11:0] outside_slot();
        logic [11:0] s;
        case ($urandom_range(0, 7))
            0: s = pr_pkg::WIN0_LO - 12'd1;
            1: s = pr_pkg::WIN0_HI + 12'd1;
            2: s = pr_pkg::WIN1_LO - 12'd1;
            3: s = pr_pkg::WIN1_HI + 12'd1;
            4: s = pr_pkg::WIN2_LO - 12'd1;
            5: s = 12'(SLOT_MAX);
            6: s = 12'd0;
            default: begin
                s = rand_slot();
                while (is_access_slot(s))
                    s = rand_slot();
            end
        endcase
        return s;
    endfunction

    // identifier that matches, nearly matches, or is random
    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return stim_own_id;
            4:          return stim_own_id ^ (32'd1 << $urandom_range(0, 31));
            default:    return $urandom();
        endcase
    endfunction

    // Paging packet: type byte, two skipped bytes, whole identifier groups,
    // sometimes a trailing partial group, end flag on the last byte. A few
    // are cut short or lose their end flag.
    task automatic send_random_packet();
        logic [7:0]  pkt [$];
        logic [7:0]  rb;
        logic [31:0] id;
        int          groups;
        int          cut;
        bit          with_eop;
        rb = $urandom();
        pkt.push_back(($urandom_range(0, 99) < 85) ? pr_pkg::PKT_TYPE : rb);
        rb = $urandom();
        pkt.push_back(rb);
        rb = $urandom();
        pkt.push_back(rb);
        groups = $urandom_range(0, 3);
        for (int g = 0; g < groups; g++) begin
            id = pick_id();
            pkt.push_back(id[31:24]);
            pkt.push_back(id[23:16]);
            pkt.push_back(id[15:8]);
            pkt.push_back(id[7:0]);
        end
        if ($urandom_range(0, 3) == 0) begin
            for (int k = $urandom_range(1, 3); k > 0; k--) begin
                rb = $urandom();
                pkt.push_back(rb);
            end
        end
        if ($urandom_range(0, 99) < 15) begin
            cut = $urandom_range(1, pkt.size());
            while (pkt.size() > cut)
                rb = pkt.pop_back();
        end
        with_eop = ($urandom_range(0, 99) >= 5);
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], with_eop && (i == pkt.size() - 1));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Register defaults after reset: own id 0, quality 100, capability 0x10.
    // Also the idle tick and the unused mode.
    task automatic test_reset_values();
        gaps_on     = 1'b0;
        stim_own_id = pr_pkg::OWN_ID_RST;
        send_page(32'd0);                   // matches default id
        send_tick(pr_pkg::WIN0_LO);         // burst with default bytes
        send_tick(pr_pkg::WIN0_LO);         // idle again: nothing
        send_item(MODE_UNUSED, 8'hFF, 1'b1, 12'hFFF, 32'hFFFF_FFFF);
        wait_for_quiet();
    endtask

    // Packet rules: first match only, repeated match while responding,
    // invalid type byte, one-byte packet, window edges.
    task automatic test_packet_rules();
        set_config(32'hFFFF_FFFF, 8'hFF, 8'hFF);
        send_byte(pr_pkg::PKT_TYPE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0);  // first group matches
        repeat (3) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);             // second match ignored
        send_page(32'hFFFF_FFFF);           // already responding: notice again
        send_tick(12'(SLOT_MAX));           // beyond last window
        send_tick(pr_pkg::WIN2_HI);
        wait_for_quiet();

        set_config(32'h0102_0304, 8'h00, 8'h00);
        send_byte(pr_pkg::PKT_TYPE, 1'b1);          // one-byte packet
        send_byte(pr_pkg::PKT_TYPE - 8'd1, 1'b0);   // wrong type, matching id
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b1);
        send_tick(pr_pkg::WIN1_LO);         // still idle: nothing
        wait_for_quiet();
    endtask

    // Receiver holds off for a long stretch while pages and ticks that all
    // cause results keep coming, so the block fills and stalls its input.
    task automatic test_backpressure();
        logic [31:0] id;
        logic [7:0]  q;
        logic [7:0]  c;
        id = $urandom();
        q  = $urandom();
        c  = $urandom();
        set_config(id, q, c);
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        repeat (5) begin
            send_page(stim_own_id);
            send_tick(window_slot());
        end
        wait_for_quiet();
    endtask

    // Random traffic in phases, one register setting per phase, extremes
    // included. Mostly packets, plus ticks, pages, stray bytes and noise.
    task automatic test_random_traffic();
        int          phase;
        int          phase_start;
        int          r;
        logic [31:0] id;
        logic [7:0]  q;
        logic [7:0]  c;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            id = $urandom();
            q  = $urandom();
            c  = $urandom();
            case (phase % 4)
                1:       set_config(32'hFFFF_FFFF, 8'hFF, 8'hFF);
                2:       set_config(32'd0, 8'h00, 8'h00);
                default: set_config(id, q, c);
            endcase
            gaps_on     = ($urandom_range(0, 3) != 0);
            burst_left  = 0;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET) begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    send_random_packet();
                else if (r < 62)
                    send_tick(window_slot());
                else if (r < 68)
                    send_tick(outside_slot());
                else if (r < 84)
                    send_page(pick_id());
                else if (r < 92)
                    send_item(MODE_UNUSED, 8'($urandom()), 1'($urandom()),
                              rand_slot(), $urandom());
                else
                    send_byte(8'($urandom()), 1'($urandom()));  // broken sequence
            end
            wait_for_quiet();
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : run_tests
        error_count  = 0;
        items_sent   = 0;
        gaps_on      = 1'b0;
        burst_left   = 0;
        hold_request = 1'b0;
        stim_own_id  = pr_pkg::OWN_ID_RST;

        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_mode          <= pr_pkg::MODE_BYTE;
        i_packet_byte   <= '0;
        i_end_of_packet <= 1'b0;
        i_slot_number   <= '0;
        i_paged_id      <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= pr_pkg::CFG_OWN_ID;
        i_cfg_data      <= '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_packet_rules();
        test_backpressure();
        test_random_traffic();
        wait_for_quiet();

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== paging_responder.f =====
+incdir+rtl
rtl/pr_pkg.sv
rtl/pr_parser.sv
rtl/pr_emitter.sv
rtl/paging_responder.sv
tb/paging_responder_tb.sv
